FILE: sv/sampled_lru_utility_monitor_top_defines.svh
// Assertion macros used by the checker file of the sampled LRU utility monitor
`ifndef SAMPLED_LRU_UTILITY_MONITOR_TOP_DEFINES_SVH
`define SAMPLED_LRU_UTILITY_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset
`define SLUM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define SLUM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/slum_pkg.sv
// Types and constants shared by the sampled LRU utility monitor
`default_nettype none

package slum_pkg;

    localparam int ADDR_W  = 48;
    localparam int HASH_W  = 32;
    localparam int CNT_W   = 32;
    localparam int POS_W   = 6;
    localparam int IDX_W   = 7;
    localparam int CMD_W   = 2;
    localparam int SBITS_W = 5;

    localparam int BUCKETS_DEF = 16;
    localparam int SETS_DEF    = 64;

    localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CURVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] line_addr;
        logic [HASH_W-1:0] sample_hash;
        logic [HASH_W-1:0] set_hash;
    } t_item;

    typedef struct packed {
        logic             sampled;
        logic             hit;
        logic [POS_W-1:0] hit_position;
        logic [IDX_W-1:0] curve_index;
        logic [CNT_W-1:0] curve_value;
        logic             last;
    } t_result;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_tag_stat;

endpackage

`default_nettype wire

FILE: sv/sampled_lru_utility_monitor_top.sv
// Top level of the sampled LRU utility monitor
`default_nettype none

// Command channel: an item transfers on a rising edge with start high and busy low.
// cmd selects an access, a miss-curve read or a counter clear. Results leave on
// o_result for one cycle each, marked by o_strobe; the receiver cannot stall.
// sample_bits is written through i_cfg_we / i_cfg_wdata; the user must do so only while
// the block is idle, which the block itself does not enforce. Per command:
//   unsampled access: the block stays idle, result in the following cycle.
//   sampled access: busy while the tag store scans the set up to the hit at stack position p,
//   or to the last position on a miss, one RAM read and one write per stack position.
//   curve read: BUCKETS+1 results in consecutive cycles, index 0 first, from one
//   shared add/subtract unit visiting each hit counter twice.
//   clear: no result; the block stays idle.
// After reset the tag store is swept to zero, one entry a cycle; busy stays high
// until the sweep ends. Counters and sample_bits reset to zero.
module sampled_lru_utility_monitor_top
    import slum_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int SETS    = SETS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_item              i_item,
    output logic                    o_strobe,
    output t_result                 o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [SBITS_W-1:0] i_cfg_wdata
);

    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int ROW_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int SET_MASK = (1 << SET_BITS) - 1;
    localparam int BW       = $clog2(BUCKETS);
    localparam int SW       = CNT_W + $clog2(BUCKETS + 1);
    localparam logic [BW-1:0] LAST_K = BW'(BUCKETS - 1);

    typedef enum logic [2:0] {S_IDLE, S_ACC, S_HINC, S_CSUM, S_CEMIT, S_CLAST} t_state;

    t_state               r_state;
    logic [SBITS_W-1:0]   r_sample_bits;
    logic [CNT_W-1:0]     r_miss;
    logic [BUCKETS-1:0]   r_hvld;
    logic [CNT_W-1:0]     r_hits_mem [BUCKETS];
    logic [CNT_W-1:0]     r_hrd;
    logic                 r_hrv;
    logic [SW-1:0]        r_acc;
    logic [BW-1:0]        r_k;
    logic [POS_W-1:0]     r_pos;
    logic                 r_strobe;
    t_result              r_res;

    t_tag_stat            tag_stat;
    logic                 accept;
    logic                 item_sampled;
    logic                 tag_start;
    logic [ROW_W-1:0]     set_sel;
    logic [CNT_W-1:0]     hv;
    logic [SW-1:0]        op_a;
    logic [SW-1:0]        op_b;
    logic                 op_sub;
    logic [SW-1:0]        sum;
    logic [CNT_W-1:0]     sum_sat;
    logic [CNT_W-1:0]     acc_sat;
    logic [BW-1:0]        k_next;
    logic [BW-1:0]        hra;
    logic                 hwe;

    assign busy         = (r_state != S_IDLE) || tag_stat.busy;
    assign accept       = start && !busy;
    assign item_sampled = ((i_item.sample_hash & ~({HASH_W{1'b1}} << r_sample_bits)) == '0);
    assign tag_start    = accept && (i_item.cmd == CMD_ACCESS) && item_sampled;
    assign set_sel      = ROW_W'(i_item.set_hash & HASH_W'(SET_MASK));

    slum_tag_store #(
        .BUCKETS (BUCKETS),
        .SETS    (SETS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tag_start),
        .i_set   (set_sel),
        .i_addr  (i_item.line_addr),
        .o_stat  (tag_stat)
    );

    // A counter never written since the last clear reads as zero
    assign hv = r_hrv ? r_hrd : '0;

    // Shared add/subtract unit: counter increments, curve accumulation and peel-off
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        unique case (r_state)
            S_ACC: begin
                op_a = SW'(r_miss);
                op_b = SW'(1);
            end
            S_HINC: begin
                op_a = SW'(hv);
                op_b = SW'(1);
            end
            S_CSUM: begin
                op_a = r_acc;
                op_b = SW'(hv);
            end
            S_CEMIT: begin
                op_a   = r_acc;
                op_b   = SW'(hv);
                op_sub = 1'b1;
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign sum     = op_sub ? (op_a - op_b) : (op_a + op_b);
    assign sum_sat = (|sum[SW-1:CNT_W]) ? CNT_MAX : sum[CNT_W-1:0];
    assign acc_sat = (|r_acc[SW-1:CNT_W]) ? CNT_MAX : r_acc[CNT_W-1:0];
    assign k_next  = (r_k == LAST_K) ? '0 : BW'(r_k + BW'(1));

    always_comb begin
        unique case (r_state)
            S_ACC:           hra = tag_stat.pos[BW-1:0];
            S_CSUM, S_CEMIT: hra = k_next;
            default:         hra = '0;
        endcase
    end

    assign hwe = (r_state == S_HINC);

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            r_hits_mem[r_pos[BW-1:0]] <= sum_sat;
        end
        r_hrd <= r_hits_mem[hra];
        r_hrv <= r_hvld[hra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strobe      <= 1'b0;
            r_sample_bits <= '0;
            r_miss        <= '0;
            r_hvld        <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_sample_bits <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        priority if (i_item.cmd == CMD_ACCESS) begin
                            if (!item_sampled) begin
                                r_strobe <= 1'b1;
                                r_res    <= '{sampled: 1'b0, hit: 1'b0, hit_position: '0,
                                              curve_index: '0, curve_value: '0, last: 1'b1};
                            end else begin
                                r_state <= S_ACC;
                            end
                        end else if (i_item.cmd == CMD_CURVE) begin
                            r_acc   <= SW'(r_miss);
                            r_k     <= '0;
                            r_state <= S_CSUM;
                        end else if (i_item.cmd == CMD_CLEAR) begin
                            r_miss <= '0;
                            r_hvld <= '0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ACC: begin
                    if (tag_stat.done) begin
                        if (tag_stat.hit) begin
                            r_pos   <= tag_stat.pos;
                            r_state <= S_HINC;
                        end else begin
                            r_miss   <= sum_sat;
                            r_strobe <= 1'b1;
                            r_res    <= '{sampled: 1'b1, hit: 1'b0, hit_position: '0,
                                          curve_index: '0, curve_value: '0, last: 1'b1};
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_HINC: begin
                    r_hvld[r_pos[BW-1:0]] <= 1'b1;
                    r_strobe <= 1'b1;
                    r_res    <= '{sampled: 1'b1, hit: 1'b1, hit_position: r_pos,
                                  curve_index: '0, curve_value: '0, last: 1'b1};
                    r_state  <= S_IDLE;
                end
                S_CSUM: begin
                    r_acc <= sum;
                    r_k   <= k_next;
                    if (r_k == LAST_K) begin
                        r_state <= S_CEMIT;
                    end
                end
                S_CEMIT: begin
                    // emit the suffix sum, then drop this position's hits from it
                    r_strobe <= 1'b1;
                    r_res    <= '{sampled: 1'b0, hit: 1'b0, hit_position: '0,
                                  curve_index: IDX_W'(r_k), curve_value: acc_sat, last: 1'b0};
                    r_acc    <= sum;
                    if (r_k == LAST_K) begin
                        r_state <= S_CLAST;
                    end else begin
                        r_k <= k_next;
                    end
                end
                S_CLAST: begin
                    r_strobe <= 1'b1;
                    r_res    <= '{sampled: 1'b0, hit: 1'b0, hit_position: '0,
                                  curve_index: IDX_W'(BUCKETS), curve_value: acc_sat,
                                  last: 1'b1};
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

FILE: sv/slum_tag_store.sv
// Sampled tag store: one RAM of line addresses, move-to-front scan per set
`default_nettype none

module slum_tag_store
    import slum_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int SETS    = SETS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [(($clog2(SETS+1)-1) > 0 ? ($clog2(SETS+1)-1) : 1)-1:0] i_set,
    input  wire logic [ADDR_W-1:0]   i_addr,
    output t_tag_stat                o_stat
);

    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int ROW_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int DEPTH    = SETS * BUCKETS;
    localparam int AW       = $clog2(DEPTH);
    localparam int BW       = $clog2(BUCKETS);
    localparam logic [BW-1:0] LAST_B   = BW'(BUCKETS - 1);
    localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN} t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_base;
    logic [BW-1:0]      r_b;
    logic [ADDR_W-1:0]  r_key;
    logic [ADDR_W-1:0]  r_carry;
    logic [ADDR_W-1:0]  r_rd;
    logic               r_done;
    logic               r_hit;
    logic [POS_W-1:0]   r_pos;
    logic [ADDR_W-1:0]  r_mem [DEPTH];

    logic [ROW_W-1:0]   set_idx;
    logic [AW-1:0]      base_now;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wa;
    logic [ADDR_W-1:0]  wd;
    logic               match;
    logic               final_step;

    assign set_idx    = i_set;
    assign base_now   = AW'(set_idx) * AW'(BUCKETS);
    assign cur_addr   = r_base + AW'(r_b);
    assign match      = (r_rd == r_key);
    assign final_step = match || (r_b == LAST_B);

    always_comb begin
        rd_addr = base_now;
        we      = 1'b0;
        wa      = cur_addr;
        wd      = r_carry;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
                wd = '0;
            end
            S_SCAN: begin
                we      = 1'b1;
                rd_addr = cur_addr + AW'(1);
            end
            default: begin
                rd_addr = base_now;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Each scan step writes the carried entry one slot down and picks up the old one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_base  <= base_now;
                        r_b     <= '0;
                        r_key   <= i_addr;
                        r_carry <= i_addr;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (final_step) begin
                        r_done  <= 1'b1;
                        r_hit   <= match;
                        r_pos   <= POS_W'(r_b);
                        r_state <= S_IDLE;
                    end else begin
                        r_carry <= r_rd;
                        r_b     <= r_b + BW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat = '{busy: (r_state != S_IDLE), done: r_done, hit: r_hit, pos: r_pos};

endmodule

`default_nettype wire

FILE: sv/slum_checker.sv
// Port-level checker for the sampled LRU utility monitor, bound to the top level
`default_nettype none

`include "sampled_lru_utility_monitor_top_defines.svh"

module slum_checker
    import slum_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire logic  busy,
    input  wire t_item i_item,
    input  wire logic  o_strobe,
    input  wire t_result o_result
);

    logic mid_burst;
    logic curve_xfer;

    assign mid_burst  = o_strobe && !o_result.last;
    assign curve_xfer = start && !busy && (i_item.cmd == CMD_CURVE);

    // curve results come out back to back until the one marked last
    `SLUM_ASSERT_NXT(a_curve_burst, i_clk, i_rst_n, mid_burst, o_strobe, "curve burst broken")

    `SLUM_ASSERT_IMP(a_busy_in_burst, i_clk, i_rst_n, mid_burst, busy, "transfer possible mid-burst")

    `SLUM_ASSERT_NXT(a_curve_busy, i_clk, i_rst_n, curve_xfer, busy, "curve read not held busy")

    `SLUM_ASSERT_IMP(a_hit_sampled, i_clk, i_rst_n, o_strobe && o_result.hit, o_result.sampled, "hit unsampled")

endmodule

bind sampled_lru_utility_monitor_top slum_checker u_slum_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
